// ----- sv/gmts_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the grid maze trail solver
// no dependencies

package gmts_pkg;

  localparam int MAX_DIM = 128;
  localparam int COORD_W = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * COORD_W;
  localparam int CELLS   = MAX_DIM * MAX_DIM;

  // trail marks
  localparam logic [1:0] MARK_NONE = 2'd0;
  localparam logic [1:0] MARK_ON   = 2'd1;
  localparam logic [1:0] MARK_OFF  = 2'd2;

  // item modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STEP  = 2'd2;
  localparam logic [1:0] MODE_MOVE  = 2'd3;

  // manual move directions
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // configuration register indexes
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // neighbour offsets, first four in solver search order
  typedef enum logic [2:0] {
    OFS_DOWN,
    OFS_RIGHT,
    OFS_LEFT,
    OFS_UP,
    OFS_STAY
  } ofs_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               in_grid;
  } coord_res_t;

endpackage

// ----- sv/gmts_ram.sv -----
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
// no dependencies

module gmts_ram #(
  parameter int DATA_W = 1,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/gmts_step_unit.sv -----
`timescale 1ns / 1ps
// shared neighbour unit: base coordinate plus offset, grid bounds check
// depends on gmts_pkg

module gmts_step_unit (
  input  logic [gmts_pkg::COORD_W-1:0] base_x,
  input  logic [gmts_pkg::COORD_W-1:0] base_y,
  input  gmts_pkg::ofs_t               ofs,
  input  logic [gmts_pkg::COORD_W-1:0] grid_width,
  input  logic [gmts_pkg::COORD_W-1:0] grid_height,
  output gmts_pkg::coord_res_t         res
);

  import gmts_pkg::*;

  logic [COORD_W:0] nx;
  logic [COORD_W:0] ny;

  always_comb begin
    nx = {1'b0, base_x};
    ny = {1'b0, base_y};
    case (ofs)
      OFS_DOWN:  ny = {1'b0, base_y} + (COORD_W+1)'(1);
      OFS_RIGHT: nx = {1'b0, base_x} + (COORD_W+1)'(1);
      OFS_LEFT:  nx = {1'b0, base_x} - (COORD_W+1)'(1);
      OFS_UP:    ny = {1'b0, base_y} - (COORD_W+1)'(1);
      default:   ;
    endcase
    // top bit set means below zero or past the store edge
    res.x       = nx[COORD_W-1:0];
    res.y       = ny[COORD_W-1:0];
    res.in_grid = !nx[COORD_W] && !ny[COORD_W] &&
                  (nx[COORD_W-1:0] < grid_width) && (ny[COORD_W-1:0] < grid_height);
  end

endmodule

// ----- sv/grid_maze_trail_solver_top.sv -----
`timescale 1ns / 1ps
// top level of the grid maze trail solver: sequencer, cell stores, result register
// depends on gmts_pkg, gmts_ram, gmts_step_unit

// One item is taken at a time and gives one result. A load item writes its wall cell
// in S_LOAD; a manual move reads its one neighbour and a solver step reads all four.
// The neighbour cells are read one per cycle through the single read port of each
// cell store. S_DRAIN drains the registered read and S_SEL picks the move.
// The trail marks are then written back one per cycle in S_WR1 and S_WR2 through the
// single write port of the mark store. A start item first sweeps every mark of the
// 16384-cell store, one cell per cycle. The result shows in the same cycle as the
// block becomes ready for the next item. While an earlier result still waits on out_tready,
// the item in work holds before it finishes. Write the configuration only while
// no item is in work, because the grid bounds are read throughout an item.
module grid_maze_trail_solver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [6:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // mode
  input  logic [23:0] in_tdata,   // cell_x, cell_y, cell_wall, direction, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // pos_x, pos_y, moved, at_end
);

  import gmts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_CLR,
    S_START,
    S_RD,
    S_DRAIN,
    S_SEL,
    S_WR1,
    S_WR2,
    S_DONE
  } state_t;

  state_t             st_r;
  logic [COORD_W-1:0] width_r;
  logic [COORD_W-1:0] height_r;
  logic [COORD_W-1:0] pos_x_r;
  logic [COORD_W-1:0] pos_y_r;
  logic [1:0]         mode_r;
  logic [COORD_W-1:0] cx_r;
  logic [COORD_W-1:0] cy_r;
  logic               wall_r;
  logic [1:0]         idx_r;
  logic [1:0]         last_r;
  logic [ADDR_W-1:0]  clr_cnt_r;
  logic               rd_pend_r;
  logic [1:0]         rd_tag_r;
  logic               rd_ing_r;
  logic [3:0]         cap_open_r;
  logic [1:0]         cap_mark_r [4];
  logic [COORD_W-1:0] tgt_x_r;
  logic [COORD_W-1:0] tgt_y_r;
  logic               mv_ok_r;
  logic               tgt_on_r;
  logic               out_valid_r;
  logic [15:0]        out_data_r;

  logic [COORD_W-1:0] base_x;
  logic [COORD_W-1:0] base_y;
  ofs_t               ofs;
  coord_res_t         unit_res;
  logic [1:0]         sel;
  logic               found;
  logic               mark_we;
  logic [ADDR_W-1:0]  mark_waddr;
  logic [1:0]         mark_wdata;
  logic [1:0]         mark_rdata;
  logic               wall_rdata;
  logic [1:0]         man_idx;
  logic               fin_go;
  logic [COORD_W-1:0] pos_x_nxt;
  logic [COORD_W-1:0] pos_y_nxt;
  logic [COORD_W:0]   end_x;
  logic [COORD_W:0]   end_y;
  logic               at_end_nxt;

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign fin_go     = (st_r == S_DONE) && (!out_valid_r || out_tready);

  // manual direction to solver order slot
  always_comb begin
    case (in_tdata[16:15])
      DIR_UP:    man_idx = 2'(OFS_UP);
      DIR_DOWN:  man_idx = 2'(OFS_DOWN);
      DIR_LEFT:  man_idx = 2'(OFS_LEFT);
      default:   man_idx = 2'(OFS_RIGHT);
    endcase
  end

  // shared unit input selection
  always_comb begin
    base_x = pos_x_r;
    base_y = pos_y_r;
    ofs    = OFS_STAY;
    case (st_r)
      S_RD:  ofs = ofs_t'({1'b0, idx_r});
      S_SEL: ofs = ofs_t'({1'b0, sel});
      S_START: begin
        base_x = COORD_W'(1);
        base_y = COORD_W'(1);
      end
      default: ;
    endcase
  end

  gmts_step_unit u_step (
    .base_x      (base_x),
    .base_y      (base_y),
    .ofs         (ofs),
    .grid_width  (width_r),
    .grid_height (height_r),
    .res         (unit_res)
  );

  // neighbour choice: a manual move takes its direction; else unmarked first, then on path, else up
  always_comb begin
    sel   = 2'(OFS_UP);
    found = 1'b0;
    if (mode_r == MODE_MOVE) begin
      sel = last_r;
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (!found && cap_open_r[i] && cap_mark_r[i] == MARK_NONE) begin
          sel   = 2'(i);
          found = 1'b1;
        end
      end
      for (int i = 0; i < 3; i++) begin
        if (!found && cap_open_r[i] && cap_mark_r[i] == MARK_ON) begin
          sel   = 2'(i);
          found = 1'b1;
        end
      end
    end
  end

  // mark store write port
  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = {pos_y_r, pos_x_r};
    mark_wdata = MARK_NONE;
    case (st_r)
      S_CLR: begin
        mark_we    = 1'b1;
        mark_waddr = clr_cnt_r;
      end
      S_START: begin
        mark_we    = unit_res.in_grid;
        mark_waddr = {unit_res.y, unit_res.x};
        mark_wdata = MARK_ON;
      end
      S_WR1: begin
        mark_we    = mv_ok_r && tgt_on_r && unit_res.in_grid;
        mark_wdata = MARK_OFF;
      end
      S_WR2: begin
        mark_we    = mv_ok_r;
        mark_waddr = {tgt_y_r, tgt_x_r};
        mark_wdata = MARK_ON;
      end
      default: ;
    endcase
  end

  gmts_ram #(.DATA_W(2), .DEPTH(CELLS)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr ({unit_res.y, unit_res.x}),
    .rdata (mark_rdata)
  );

  gmts_ram #(.DATA_W(1), .DEPTH(CELLS)) u_wall_ram (
    .clk   (clk),
    .we    (st_r == S_LOAD),
    .waddr ({cy_r, cx_r}),
    .wdata (wall_r),
    .raddr ({unit_res.y, unit_res.x}),
    .rdata (wall_rdata)
  );

  // position and result after the item
  always_comb begin
    pos_x_nxt  = mv_ok_r ? tgt_x_r : pos_x_r;
    pos_y_nxt  = mv_ok_r ? tgt_y_r : pos_y_r;
    end_x      = {1'b0, width_r} - (COORD_W+1)'(2);
    end_y      = {1'b0, height_r} - (COORD_W+1)'(2);
    at_end_nxt = ({1'b0, pos_x_nxt} == end_x) && ({1'b0, pos_y_nxt} == end_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      width_r     <= COORD_W'(21);
      height_r    <= COORD_W'(21);
      pos_x_r     <= COORD_W'(1);
      pos_y_r     <= COORD_W'(1);
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      mv_ok_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_GRID_WIDTH:  width_r  <= cfg_data;
          REG_GRID_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_tready && !fin_go) begin
        out_valid_r <= 1'b0;
      end
      rd_pend_r <= (st_r == S_RD);
      if (rd_pend_r) begin
        cap_open_r[rd_tag_r] <= rd_ing_r && !wall_rdata;
        cap_mark_r[rd_tag_r] <= rd_ing_r ? mark_rdata : MARK_NONE;
      end
      case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            mode_r  <= in_tuser;
            cx_r    <= in_tdata[6:0];
            cy_r    <= in_tdata[13:7];
            wall_r  <= in_tdata[14];
            mv_ok_r <= 1'b0;
            case (in_tuser)
              MODE_LOAD: st_r <= S_LOAD;
              MODE_START: begin
                clr_cnt_r <= '0;
                st_r      <= S_CLR;
              end
              MODE_STEP: begin
                idx_r  <= 2'(OFS_DOWN);
                last_r <= 2'(OFS_UP);
                st_r   <= S_RD;
              end
              default: begin
                idx_r  <= man_idx;
                last_r <= man_idx;
                st_r   <= S_RD;
              end
            endcase
          end
        end
        S_LOAD: st_r <= S_DONE;
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
          if (clr_cnt_r == ADDR_W'(CELLS - 1)) begin
            st_r <= S_START;
          end
        end
        S_START: begin
          pos_x_r <= COORD_W'(1);
          pos_y_r <= COORD_W'(1);
          st_r    <= S_DONE;
        end
        S_RD: begin
          rd_tag_r  <= idx_r;
          rd_ing_r  <= unit_res.in_grid;
          idx_r     <= idx_r + 2'd1;
          if (idx_r == last_r) begin
            st_r <= S_DRAIN;
          end
        end
        S_DRAIN: st_r <= S_SEL;
        S_SEL: begin
          tgt_x_r  <= unit_res.x;
          tgt_y_r  <= unit_res.y;
          mv_ok_r  <= cap_open_r[sel];
          tgt_on_r <= (cap_mark_r[sel] == MARK_ON);
          st_r     <= S_WR1;
        end
        S_WR1: st_r <= S_WR2;
        S_WR2: st_r <= S_DONE;
        S_DONE: begin
          if (fin_go) begin
            pos_x_r     <= pos_x_nxt;
            pos_y_r     <= pos_y_nxt;
            out_valid_r <= 1'b1;
            out_data_r  <= {at_end_nxt, mv_ok_r, pos_y_nxt, pos_x_nxt};
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item taken while another is in work");

  a_no_mark_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> !mark_we)
    else $error("mark store written with no item in work");

  a_moved_changes_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && mv_ok_r) |=> (pos_x_r != $past(pos_x_r) || pos_y_r != $past(pos_y_r)))
    else $error("move reported but position unchanged");

  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_valid_r)
    else $error("finished item gave no result");
`endif

endmodule
